>>> hdl/dstm_pkg.sv
// Shared types, codes and constants of the duration string to minutes block.
package dstm_pkg;

  localparam int ACC_WIDTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_YEAR  = 2'd0;
  localparam logic [1:0] CFG_MONTH = 2'd1;

  // token kinds handed from front to back
  localparam logic [2:0] TOK_DIGIT  = 3'd0;
  localparam logic [2:0] TOK_YEAR   = 3'd1;
  localparam logic [2:0] TOK_DAY    = 3'd2;
  localparam logic [2:0] TOK_HOUR   = 3'd3;
  localparam logic [2:0] TOK_MINUTE = 3'd4;
  localparam logic [2:0] TOK_BAD    = 3'd5;
  localparam logic [2:0] TOK_TERM   = 3'd6;

  localparam logic [3:0] PREFIX_LEN  = 4'd9;
  localparam logic [3:0] PREFIX_FAIL = 4'd15;

  // floor(2^32 / 25), used for quotient estimates by 25
  localparam logic [31:0] RECIP_25 = 32'd171798691;

  localparam logic [31:0] MIN_PER_YEAR = 32'd525600;
  localparam logic [31:0] MIN_PER_DAY  = 32'd1440;
  localparam logic [31:0] MIN_PER_HOUR = 32'd60;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] digit;
    logic       perm;
  } token_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
  } cfg_t;

  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0: c = 8'h70;  // p
      4'd1: c = 8'h65;  // e
      4'd2: c = 8'h72;  // r
      4'd3: c = 8'h6d;  // m
      4'd4: c = 8'h61;  // a
      4'd5: c = 8'h6e;  // n
      4'd6: c = 8'h65;  // e
      4'd7: c = 8'h6e;  // n
      4'd8: c = 8'h74;  // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/dstm_front.sv
// Front end: accepts characters, classifies them and tracks the permanent prefix.
module dstm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           character,
  input  logic                 queue_ready,
  output logic                 push,
  output dstm_pkg::token_t     token
);

  logic [3:0] prefix_progress;
  logic [3:0] prefix_progress_next;

  assign in_ready = queue_ready;
  assign push     = in_valid && queue_ready;

  always_comb begin
    token.digit = 4'(character - 8'h30);
    token.perm  = (prefix_progress == dstm_pkg::PREFIX_LEN);
    if (character == 8'h00) begin
      token.kind = dstm_pkg::TOK_TERM;
    end else if (character >= 8'h30 && character <= 8'h39) begin
      token.kind = dstm_pkg::TOK_DIGIT;
    end else if (character == 8'h79) begin
      token.kind = dstm_pkg::TOK_YEAR;
    end else if (character == 8'h64) begin
      token.kind = dstm_pkg::TOK_DAY;
    end else if (character == 8'h68) begin
      token.kind = dstm_pkg::TOK_HOUR;
    end else if (character == 8'h6d) begin
      token.kind = dstm_pkg::TOK_MINUTE;
    end else begin
      token.kind = dstm_pkg::TOK_BAD;
    end
  end

  always_comb begin
    prefix_progress_next = prefix_progress;
    if (character == 8'h00) begin
      prefix_progress_next = 4'd0;
    end else if (prefix_progress < dstm_pkg::PREFIX_LEN) begin
      if (character == dstm_pkg::prefix_char(prefix_progress)) begin
        prefix_progress_next = prefix_progress + 4'd1;
      end else begin
        prefix_progress_next = dstm_pkg::PREFIX_FAIL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_progress <= 4'd0;
    end else if (push) begin
      prefix_progress <= prefix_progress_next;
    end
  end

endmodule

>>> hdl/dstm_queue.sv
// Short token queue between front and back.
module dstm_queue #(
  parameter int DEPTH = dstm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dstm_pkg::token_t push_token,
  output logic             ready,
  input  logic             pop,
  output logic             head_valid,
  output dstm_pkg::token_t head_token
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dstm_pkg::token_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready      = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_token = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/dstm_back.sv
// Back end: accumulates amounts and runs the leap count and minute total sequence.
module dstm_back #(
  parameter int ACC_WIDTH = dstm_pkg::ACC_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  dstm_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  dstm_pkg::token_t   q_token,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] expiration_minutes,
  output logic               parse_error
);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_CALC = 1'b1;

  localparam logic [3:0] STEP_DIV0   = 4'd0;
  localparam logic [3:0] STEP_DIV1   = 4'd1;
  localparam logic [3:0] STEP_DIV2   = 4'd2;
  localparam logic [3:0] STEP_DIV3   = 4'd3;
  localparam logic [3:0] STEP_YEAR   = 4'd4;
  localparam logic [3:0] STEP_LEAP   = 4'd5;
  localparam logic [3:0] STEP_DAY    = 4'd6;
  localparam logic [3:0] STEP_HOUR   = 4'd7;
  localparam logic [3:0] STEP_FINAL  = 4'd8;

  logic                 state;
  logic [3:0]           step;
  logic [ACC_WIDTH-1:0] digit_accumulator;
  logic [31:0]          year_amount;
  logic [31:0]          day_amount;
  logic [31:0]          hour_amount;
  logic [31:0]          minute_amount;
  logic                 error_seen;
  logic [31:0]          leap_acc;
  logic [31:0]          total;
  logic [63:0]          prod;

  logic                 out_free;
  logic                 out_load;
  logic                 is_term;
  logic                 special;
  logic                 year_pos;
  logic [31:0]          start_year;
  logic [31:0]          stop_year;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [31:0]          prev_v;
  logic [31:0]          q_est;
  logic [31:0]          rem;
  logic [31:0]          q_fix;
  logic [31:0]          final_total;
  logic [ACC_WIDTH-1:0] acc_times10;

  function automatic logic [31:0] div_in(input logic [1:0] k, input logic [31:0] s,
                                         input logic [31:0] e);
    logic [31:0] v;
    unique case (k)
      2'd0: v = (s + 32'd99) >> 2;
      2'd1: v = (s + 32'd399) >> 4;
      2'd2: v = (e + 32'd99) >> 2;
      default: v = (e + 32'd399) >> 4;
    endcase
    return v;
  endfunction

  assign out_free    = !out_valid || out_ready;
  assign is_term     = (q_token.kind == dstm_pkg::TOK_TERM);
  assign special     = q_token.perm || error_seen || (digit_accumulator != '0);
  assign year_pos    = (year_amount != 32'd0) && !year_amount[31];
  assign start_year  = 32'(cfg.year) + ((cfg.month > 4'd1) ? 32'd1 : 32'd0);
  assign stop_year   = start_year + year_amount;
  assign acc_times10 = (digit_accumulator << 3) + (digit_accumulator << 1)
                     + ACC_WIDTH'(q_token.digit);

  // pop a term only when its result can be placed or the sequence starts
  assign q_pop = (state == ST_RUN) && q_valid && (!is_term || !special || out_free);

  assign out_load = (state == ST_RUN) ? (q_pop && is_term && special)
                                      : ((step == STEP_FINAL) && out_free);

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (step)
      STEP_DIV0, STEP_DIV1, STEP_DIV2, STEP_DIV3: begin
        mul_a = div_in(step[1:0], start_year, stop_year);
        mul_b = dstm_pkg::RECIP_25;
      end
      STEP_YEAR: begin
        mul_a = year_amount;
        mul_b = dstm_pkg::MIN_PER_YEAR;
      end
      STEP_LEAP: begin
        mul_a = year_pos ? leap_acc : 32'd0;
        mul_b = dstm_pkg::MIN_PER_DAY;
      end
      STEP_DAY: begin
        mul_a = day_amount;
        mul_b = dstm_pkg::MIN_PER_DAY;
      end
      STEP_HOUR: begin
        mul_a = hour_amount;
        mul_b = dstm_pkg::MIN_PER_HOUR;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // correct the reciprocal estimate of the previous step's quotient by 25
  always_comb begin
    prev_v = div_in(2'(step - 4'd1), start_year, stop_year);
    q_est  = prod[63:32];
    rem    = prev_v - ((q_est << 4) + (q_est << 3) + q_est);
    q_fix  = q_est + ((rem >= 32'd25) ? 32'd1 : 32'd0);
  end

  assign final_total = total + prod[31:0];

  always_ff @(posedge clk) begin
    if (state == ST_CALC && step != STEP_FINAL) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_RUN;
      step              <= STEP_DIV0;
      digit_accumulator <= '0;
      year_amount       <= 32'd0;
      day_amount        <= 32'd0;
      hour_amount       <= 32'd0;
      minute_amount     <= 32'd0;
      error_seen        <= 1'b0;
      out_valid         <= 1'b0;
      leap_acc          <= 32'd0;
      total             <= 32'd0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (state == ST_RUN) begin
        if (q_pop) begin
          if (is_term) begin
            if (special) begin
              out_valid          <= 1'b1;
              expiration_minutes <= 32'sd0;
              parse_error        <= !q_token.perm;
              digit_accumulator  <= '0;
              year_amount        <= 32'd0;
              day_amount         <= 32'd0;
              hour_amount        <= 32'd0;
              minute_amount      <= 32'd0;
              error_seen         <= 1'b0;
            end else begin
              state <= ST_CALC;
              step  <= STEP_DIV0;
            end
          end else if (!error_seen) begin
            unique case (q_token.kind)
              dstm_pkg::TOK_DIGIT: digit_accumulator <= acc_times10;
              dstm_pkg::TOK_YEAR: begin
                year_amount       <= 32'(digit_accumulator);
                digit_accumulator <= '0;
              end
              dstm_pkg::TOK_DAY: begin
                day_amount        <= 32'(digit_accumulator);
                digit_accumulator <= '0;
              end
              dstm_pkg::TOK_HOUR: begin
                hour_amount       <= 32'(digit_accumulator);
                digit_accumulator <= '0;
              end
              dstm_pkg::TOK_MINUTE: begin
                minute_amount     <= 32'(digit_accumulator);
                digit_accumulator <= '0;
              end
              default: begin
                error_seen        <= 1'b1;
                digit_accumulator <= '0;
              end
            endcase
          end
        end
      end else begin
        unique case (step)
          STEP_DIV0: begin
            leap_acc <= ((stop_year + 32'd3) >> 2) - ((start_year + 32'd3) >> 2);
            total    <= minute_amount;
          end
          STEP_DIV1: leap_acc <= leap_acc + q_fix;
          STEP_DIV2: leap_acc <= leap_acc - q_fix;
          STEP_DIV3: leap_acc <= leap_acc - q_fix;
          STEP_YEAR: leap_acc <= leap_acc + q_fix;
          STEP_LEAP, STEP_DAY, STEP_HOUR: total <= total + prod[31:0];
          default: begin
            // hold the finished total until the output register frees up
            if (out_free) begin
              out_valid          <= 1'b1;
              expiration_minutes <= $signed(final_total);
              parse_error        <= 1'b0;
              digit_accumulator  <= '0;
              year_amount        <= 32'd0;
              day_amount         <= 32'd0;
              hour_amount        <= 32'd0;
              minute_amount      <= 32'd0;
              error_seen         <= 1'b0;
              state              <= ST_RUN;
            end
          end
        endcase
        if (step != STEP_FINAL) begin
          step <= step + 4'd1;
        end
      end
    end
  end

endmodule

>>> hdl/duration_string_to_minutes.sv
// Top level: duration string parser with decoupled front and back ends.
//
// Usage: characters of a duration string such as 3y10d4h5m arrive on the
// in channel (in_valid, in_ready, character), byte 0 ends the string. One
// word leaves on the out channel (out_valid, out_ready) per terminator:
// expiration_minutes and parse_error. A string starting with permanent
// yields 0 with no error; a bad character or a nonzero number with no
// unit yields 0 with parse_error set.
// Throughput: one character per cycle while the queue has room. The front
// classifies each character as it is accepted and pushes a token into a
// four entry queue; the back pops one token per cycle when not busy with a
// terminator. A terminator holds the back while one shared multiplier runs
// four quotient estimates for the leap count and four minute products, then
// loads the total into the output register; a terminator ending in the
// permanent or error case loads its result directly. A stalled receiver
// holds the result in the output register; the back then waits and the
// queue fills, after which in_ready drops. Reset (rst, synchronous) empties
// the queue, clears all string state and sets cfg.year to 1970 and cfg.month
// to 0. cfg_we writes register cfg_index (0 year, 1 month) from cfg_data;
// the user must write only while the block is idle, unchecked by the block.
module duration_string_to_minutes #(
  parameter int ACC_WIDTH   = dstm_pkg::ACC_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = dstm_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         character,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] expiration_minutes,
  output logic               parse_error
);

  dstm_pkg::cfg_t   cfg;
  dstm_pkg::token_t push_token;
  dstm_pkg::token_t head_token;
  logic             push;
  logic             queue_ready;
  logic             head_valid;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.year  <= 16'd1970;
      cfg.month <= 4'd0;
    end else if (cfg_we) begin
      if (cfg_index == dstm_pkg::CFG_YEAR) begin
        cfg.year <= cfg_data;
      end else if (cfg_index == dstm_pkg::CFG_MONTH) begin
        cfg.month <= cfg_data[3:0];
      end
    end
  end

  dstm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .character   (character),
    .queue_ready (queue_ready),
    .push        (push),
    .token       (push_token)
  );

  dstm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .ready      (queue_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_token (head_token)
  );

  dstm_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .q_valid            (head_valid),
    .q_token            (head_token),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .expiration_minutes (expiration_minutes),
    .parse_error        (parse_error)
  );

endmodule

>>> sim/dstm_checker.sv
// Checker: predicts the minute totals of each duration string and compares result words.
module dstm_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         character,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] expiration_minutes,
  input  logic               parse_error,
  output int                 failures,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  CH_TERM   = 8'h00;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  localparam logic [7:0]  CH_YEAR   = 8'h79;
  localparam logic [7:0]  CH_DAY    = 8'h64;
  localparam logic [7:0]  CH_HOUR   = 8'h68;
  localparam logic [7:0]  CH_MINUTE = 8'h6d;
  localparam logic [71:0] PERM_WORD = "permanent";

  localparam logic [31:0] YEAR_MINUTES = 32'd525600;
  localparam logic [31:0] DAY_MINUTES  = 32'd1440;
  localparam logic [31:0] HOUR_MINUTES = 32'd60;

  typedef struct packed {
    logic [31:0] minutes;
    logic        error;
  } duration_total_t;

  duration_total_t expected_totals[$];
  duration_total_t oldest_total;

  logic [15:0] now_year;
  logic [3:0]  now_month;
  logic [31:0] number_acc;
  logic [31:0] years, days, hours, mins;
  logic        bad_seen;
  logic [3:0]  perm_match;

  int miss_count = 0;
  int pending = 0;

  assign failures    = miss_count;
  assign outstanding = pending;

  // Gregorian leap years in [0, x)
  function automatic longint unsigned leap_years_below(input longint unsigned x);
    return (x + 3) / 4 - (x + 99) / 100 + (x + 399) / 400;
  endfunction

  task automatic clear_string();
    number_acc = '0;
    years      = '0;
    days       = '0;
    hours      = '0;
    mins       = '0;
    bad_seen   = 1'b0;
    perm_match = '0;
  endtask

  task automatic take_character(input logic [7:0] c);
    duration_total_t  total;
    longint unsigned  first_year;
    longint unsigned  leaps;
    int               pos;
    if (c != CH_TERM) begin
      if (perm_match < dstm_pkg::PREFIX_LEN) begin
        pos = 71 - 8 * int'(perm_match);
        perm_match = (c == PERM_WORD[pos -: 8]) ? perm_match + 4'd1
                                                : dstm_pkg::PREFIX_FAIL;
      end
      if (!bad_seen) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          number_acc = number_acc * 32'd10 + {24'd0, c - CH_ZERO};
        end else begin
          case (c)
            CH_YEAR:   years = number_acc;
            CH_DAY:    days  = number_acc;
            CH_HOUR:   hours = number_acc;
            CH_MINUTE: mins  = number_acc;
            default:   bad_seen = 1'b1;
          endcase
          number_acc = '0;
        end
      end
    end else begin
      total.minutes = '0;
      total.error   = 1'b0;
      if (perm_match == dstm_pkg::PREFIX_LEN) begin
        total.minutes = '0;
      end else if (bad_seen || number_acc != 0) begin
        total.error = 1'b1;
      end else begin
        leaps = 0;
        // negative year amounts cross no leap days
        if (years != 0 && !years[31]) begin
          first_year = longint'(now_year) + ((now_month > 4'd1) ? 1 : 0);
          leaps = leap_years_below(first_year + years) - leap_years_below(first_year);
        end
        total.minutes = years * YEAR_MINUTES + leaps[31:0] * DAY_MINUTES
                      + days * DAY_MINUTES + hours * HOUR_MINUTES + mins;
      end
      expected_totals.push_back(total);
      clear_string();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      now_year  = 16'd1970;
      now_month = 4'd0;
      clear_string();
      expected_totals.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == dstm_pkg::CFG_YEAR) now_year = cfg_data;
        else if (cfg_index == dstm_pkg::CFG_MONTH) now_month = cfg_data[3:0];
      end
      if (in_valid && in_ready) take_character(character);
      if (out_valid && out_ready) begin
        if (expected_totals.size() == 0) begin
          $error("result word with nothing expected: expiration_minutes %0d parse_error %0b",
                 expiration_minutes, parse_error);
          miss_count++;
        end else begin
          oldest_total = expected_totals.pop_front();
          if (expiration_minutes !== oldest_total.minutes) begin
            $error("expiration_minutes: expected %0d, actual %0d",
                   $signed(oldest_total.minutes), expiration_minutes);
            miss_count++;
          end
          if (parse_error !== oldest_total.error) begin
            $error("parse_error: expected %0b, actual %0b", oldest_total.error, parse_error);
            miss_count++;
          end
        end
      end
    end
    pending = expected_totals.size();
  end

endmodule

>>> sim/duration_string_to_minutes_tb.sv
// Testbench top: drives duration strings and register writes, gives the verdict.
module duration_string_to_minutes_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CYCLE_LIMIT   = 400000;
  localparam int  DRAIN_CYCLES  = 16;
  localparam int  HOLD_CYCLES   = 80;
  localparam int  PHASES        = 6;
  localparam int  PHASE_CHARS   = 305;
  localparam logic [7:0] CH_TERM = 8'h00;
  localparam string PERM_TEXT   = "permanent";
  localparam string UNIT_TEXT   = "ydhm";

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         character;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] expiration_minutes;
  logic               parse_error;
  int                 failures;
  int                 outstanding;

  logic [7:0] text_bytes[$];
  bit         idle_on = 1'b1;
  bit         hold_request = 1'b0;
  int         chars_sent = 0;
  int         cycle_count = 0;

  always #10 clk = ~clk;

  duration_string_to_minutes DUT (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .character,
    .out_valid, .out_ready, .expiration_minutes, .parse_error
  );

  dstm_checker u_check (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .character,
    .out_valid, .out_ready, .expiration_minutes, .parse_error,
    .failures, .outstanding
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endtask

  task automatic push_value(input longint unsigned v);
    push_text($sformatf("%0d", v));
  endtask

  // amount ahead of a unit: often small, sometimes wide or wrapping
  task automatic push_amount();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick % 7 == 0) text_bytes.push_back("0");
    if (pick < 10) begin
      // unit alone
    end else if (pick < 70) begin
      push_value(64'($urandom_range(0, 999)));
    end else if (pick < 85) begin
      push_value(64'($urandom_range(0, 100000)));
    end else if (pick < 93) begin
      push_value(64'($urandom));
    end else begin
      repeat ($urandom_range(10, 20))
        text_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic push_segments(input int count);
    repeat (count) begin
      push_amount();
      text_bytes.push_back(UNIT_TEXT[$urandom_range(0, 3)]);
    end
  endtask

  task automatic make_duration_text();
    int kind;
    int cut;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      push_segments($urandom_range(1, 4));
    end else if (kind < 70) begin
      push_text(PERM_TEXT);
      if ($urandom_range(0, 1)) push_segments($urandom_range(0, 2));
      else repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom_range(1, 255)));
    end else if (kind < 78) begin
      cut = $urandom_range(1, 8);
      for (int i = 0; i < cut; i++) text_bytes.push_back(PERM_TEXT[i]);
      push_segments($urandom_range(0, 2));
    end else if (kind < 90) begin
      push_segments($urandom_range(0, 2));
      text_bytes.push_back(8'($urandom_range(1, 255)));
      push_segments($urandom_range(0, 2));
    end else begin
      push_segments($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) push_text("0");
      else push_value(64'($urandom_range(0, 99999)));
    end
    text_bytes.push_back(CH_TERM);
  endtask

  // enter and leave at a falling edge; valid stays up between words
  task automatic send_char(input logic [7:0] c);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    character <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_bytes[i]) send_char(text_bytes[i]);
    text_bytes.delete();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] year_set;
    logic [3:0]  month_set;
    int          budget;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    character = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: permanent, every unit, pending digits, pending zero, high byte, empty
    push_text(PERM_TEXT);
    text_bytes.push_back(CH_TERM);
    push_text("1y2d3h4m");
    text_bytes.push_back(CH_TERM);
    push_text("7");
    text_bytes.push_back(CH_TERM);
    push_text("0");
    text_bytes.push_back(CH_TERM);
    text_bytes.push_back(8'hFF);
    text_bytes.push_back(CH_TERM);
    text_bytes.push_back(CH_TERM);
    send_text();

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin year_set = 16'd1970;  month_set = 4'd0;  end
        1: begin year_set = 16'd65535; month_set = 4'd11; end
        2: begin year_set = 16'd2000;  month_set = 4'd1;  end
        3: begin year_set = 16'd2099;  month_set = 4'd2;  end
        4: begin
          year_set  = 16'($urandom_range(1970, 65535));
          month_set = 4'($urandom_range(12, 15));
        end
        default: begin
          year_set  = 16'($urandom_range(1970, 65535));
          month_set = 4'($urandom_range(0, 11));
        end
      endcase
      write_reg(dstm_pkg::CFG_YEAR, year_set);
      write_reg(dstm_pkg::CFG_MONTH, {12'd0, month_set});
      if (p == 1) hold_request = 1'b1;
      if (p == PHASES - 1) idle_on = 1'b0;
      budget = chars_sent + PHASE_CHARS;
      while (chars_sent < budget) begin
        make_duration_text();
        send_text();
      end
    end

    wait_idle();
    if (failures == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
hdl/dstm_pkg.sv
hdl/dstm_front.sv
hdl/dstm_queue.sv
hdl/dstm_back.sv
hdl/duration_string_to_minutes.sv
sim/dstm_checker.sv
sim/duration_string_to_minutes_tb.sv
